// ===== hdl/dsch_pkg.sv =====
package dsch_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int BLOCK_BITS  = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PRIO_W      = 4;
    localparam int LEVEL_W     = 3;
    localparam int MODE_W      = 2;
    localparam int TAG_W       = 8;
    localparam int DELAY_W     = 8;
    localparam int LAT_W       = 48;
    localparam int TOT_W       = 32;
    localparam int PEND_W      = 4;

    localparam logic [PRIO_W-1:0] KERNEL_PRIORITY = PRIO_W'(8);

    // s_tdata layout
    localparam int S_BLOCK_LO = 0;
    localparam int S_WRITE_LO = S_BLOCK_LO + BLOCK_BITS;
    localparam int S_MODE_LO  = S_WRITE_LO + 1;
    localparam int S_TAG_LO   = S_MODE_LO + MODE_W;
    localparam int S_OWNER_LO = S_TAG_LO + TAG_W;
    localparam int S_LEVEL_LO = S_OWNER_LO + 1;
    localparam int S_FIELDS_W = S_LEVEL_LO + LEVEL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // m_tdata layout
    localparam int M_FIELDS_W = BLOCK_BITS + 1 + MODE_W + TAG_W + BLOCK_BITS + LAT_W
                                + 2 * TOT_W + PEND_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        OP_SUBMIT = 1'b0,
        OP_DRAIN  = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_POLICY    = 1'b0,
        REG_ROT_DELAY = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        POL_FCFS = 1'b0,
        POL_SSTF = 1'b1
    } policy_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_FLUSH,
        ST_UPDATE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] block;
        logic                  is_write;
        logic [MODE_W-1:0]     mode;
        logic [TAG_W-1:0]      tag;
        logic [PRIO_W-1:0]     prio;
    } slot_entry_t;

    typedef struct packed {
        logic                  en;
        logic                  is_write;
        logic [BLOCK_BITS-1:0] seek;
    } stats_upd_t;

endpackage

// ===== hdl/disk_request_scheduler_sstf.sv =====
// Disk request scheduler holding up to eight pending block requests. A submit
// (s_tuser = 0) stores its request in the lowest free slot and then services one
// request; a drain (s_tuser = 1) only services one, and gives no result when the
// table is empty. cfg index 0 selects the policy (0 lowest valid slot, 1 shortest
// seek first, ties to the lower priority level, kernel requests last), index 1 the
// rotational delay added to the latency total per service. One item is handled at
// a time: a submit that fits first writes its slot, then every slot is read and
// compared, and the pick is released and counted before its result is loaded.
// The slot RAM's single read port feeds one comparator one slot per cycle. A
// finished result sits in the output register, so the next item is taken while
// it waits for m_tready.
module disk_request_scheduler_sstf (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [dsch_pkg::DELAY_W-1:0]     cfg_data,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // block_number[15:0], is_write[16], transfer_mode[18:17], buffer_tag[26:19],
    // has_owner[27], owner_level[30:28], zero[31]
    input  logic [dsch_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode[0]
    input  logic                             s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_block_number[15:0], out_is_write[16], out_transfer_mode[18:17],
    // out_buffer_tag[26:19], seek_distance[42:27], latency_total[90:43],
    // read_total[122:91], write_total[154:123], pending_count[158:155], zero[159]
    output logic [dsch_pkg::M_TDATA_W-1:0]   m_tdata,
    // full_error[0]
    output logic                             m_tuser
);

    dsch_pkg::state_t                state_reg, state_next;
    dsch_pkg::policy_t               policy_reg;
    logic [dsch_pkg::DELAY_W-1:0]    rot_delay_reg;

    logic [dsch_pkg::TABLE_DEPTH-1:0] slot_valid_reg;
    logic [dsch_pkg::CNT_W-1:0]      occ_reg;
    logic [dsch_pkg::BLOCK_BITS-1:0] head_reg;

    dsch_pkg::slot_entry_t           req_reg;
    dsch_pkg::slot_entry_t           in_entry;
    logic [dsch_pkg::IDX_W-1:0]      free_idx_reg, free_idx;
    logic                            full_reg;
    logic                            table_full;

    logic [dsch_pkg::IDX_W-1:0]      scan_idx_reg;
    logic                            cmp_en_reg;
    logic [dsch_pkg::IDX_W-1:0]      cmp_idx_reg;

    logic                            best_found_reg;
    logic [dsch_pkg::IDX_W-1:0]      best_idx_reg;
    dsch_pkg::slot_entry_t           best_entry_reg;
    logic [dsch_pkg::BLOCK_BITS-1:0] lead_seek_reg;

    logic                            m_tvalid_reg;
    logic [dsch_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic                            m_tuser_reg;

    logic                            s_xfer;
    logic                            out_free;
    logic                            ram_we;
    logic                            scan_go;
    logic                            load_out;
    logic [$bits(dsch_pkg::slot_entry_t)-1:0] ram_rdata;
    dsch_pkg::slot_entry_t           rd_entry;
    logic [dsch_pkg::BLOCK_BITS-1:0] cand_dist;
    logic                            cand_better;
    logic                            take_cand;
    dsch_pkg::stats_upd_t            stats_upd;
    logic [dsch_pkg::LAT_W-1:0]      latency_total;
    logic [dsch_pkg::TOT_W-1:0]      read_total;
    logic [dsch_pkg::TOT_W-1:0]      write_total;

    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign table_full = &slot_valid_reg;
    assign rd_entry  = dsch_pkg::slot_entry_t'(ram_rdata);
    assign take_cand = cmp_en_reg && slot_valid_reg[cmp_idx_reg] && cand_better;

    always_comb begin
        in_entry.block    = s_tdata[dsch_pkg::S_BLOCK_LO +: dsch_pkg::BLOCK_BITS];
        in_entry.is_write = s_tdata[dsch_pkg::S_WRITE_LO];
        in_entry.mode     = s_tdata[dsch_pkg::S_MODE_LO +: dsch_pkg::MODE_W];
        in_entry.tag      = s_tdata[dsch_pkg::S_TAG_LO +: dsch_pkg::TAG_W];
        if (s_tdata[dsch_pkg::S_OWNER_LO]) begin
            in_entry.prio = dsch_pkg::PRIO_W'(s_tdata[dsch_pkg::S_LEVEL_LO +: dsch_pkg::LEVEL_W]);
        end else begin
            in_entry.prio = dsch_pkg::KERNEL_PRIORITY;
        end
    end

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = dsch_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                free_idx = dsch_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dsch_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    if (dsch_pkg::opcode_t'(s_tuser) == dsch_pkg::OP_SUBMIT && !table_full) begin
                        state_next = dsch_pkg::ST_INSERT;
                    end else if (occ_reg == '0) begin
                        state_next = dsch_pkg::ST_IDLE;
                    end else begin
                        state_next = dsch_pkg::ST_SCAN;
                    end
                end
            end
            dsch_pkg::ST_INSERT: state_next = dsch_pkg::ST_SCAN;
            dsch_pkg::ST_SCAN: begin
                if (scan_idx_reg == dsch_pkg::IDX_W'(dsch_pkg::TABLE_DEPTH - 1)) begin
                    state_next = dsch_pkg::ST_FLUSH;
                end
            end
            dsch_pkg::ST_FLUSH:  state_next = dsch_pkg::ST_UPDATE;
            dsch_pkg::ST_UPDATE: state_next = dsch_pkg::ST_OUTPUT;
            dsch_pkg::ST_OUTPUT: begin
                if (out_free) begin
                    state_next = dsch_pkg::ST_IDLE;
                end
            end
            default: state_next = dsch_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        ram_we   = 1'b0;
        scan_go  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            dsch_pkg::ST_IDLE:   s_tready = 1'b1;
            dsch_pkg::ST_INSERT: ram_we   = 1'b1;
            dsch_pkg::ST_SCAN:   scan_go  = 1'b1;
            dsch_pkg::ST_OUTPUT: load_out = out_free;
            default: ;
        endcase
        stats_upd.en       = (state_reg == dsch_pkg::ST_UPDATE);
        stats_upd.is_write = best_entry_reg.is_write;
        stats_upd.seek     = lead_seek_reg;
    end

    dsch_ram #(
        .WIDTH ($bits(dsch_pkg::slot_entry_t)),
        .DEPTH (dsch_pkg::TABLE_DEPTH)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (req_reg),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    dsch_seek_unit u_seek (
        .head       (head_reg),
        .entry      (rd_entry),
        .policy     (policy_reg),
        .best_found (best_found_reg),
        .lead_seek  (lead_seek_reg),
        .best_prio  (best_entry_reg.prio),
        .seek_len   (cand_dist),
        .better     (cand_better)
    );

    dsch_stats u_stats (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .upd           (stats_upd),
        .rot_delay     (rot_delay_reg),
        .latency_total (latency_total),
        .read_total    (read_total),
        .write_total   (write_total)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dsch_pkg::ST_IDLE;
            policy_reg     <= dsch_pkg::POL_FCFS;
            rot_delay_reg  <= dsch_pkg::DELAY_W'(1);
            slot_valid_reg <= '0;
            occ_reg        <= '0;
            head_reg       <= '0;
            scan_idx_reg   <= '0;
            cmp_en_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cmp_en_reg <= scan_go;
            if (cfg_valid && cfg_ready) begin
                case (dsch_pkg::cfg_reg_t'(cfg_index))
                    dsch_pkg::REG_POLICY:    policy_reg    <= dsch_pkg::policy_t'(cfg_data[0]);
                    dsch_pkg::REG_ROT_DELAY: rot_delay_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_xfer) begin
                best_found_reg <= 1'b0;
                scan_idx_reg   <= '0;
            end
            if (ram_we) begin
                slot_valid_reg[free_idx_reg] <= 1'b1;
                occ_reg <= occ_reg + 1'b1;
            end
            if (scan_go) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (take_cand) begin
                best_found_reg <= 1'b1;
            end
            if (stats_upd.en) begin
                slot_valid_reg[best_idx_reg] <= 1'b0;
                occ_reg  <= occ_reg - 1'b1;
                head_reg <= best_entry_reg.block;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_reg      <= in_entry;
            free_idx_reg <= free_idx;
            full_reg     <= (dsch_pkg::opcode_t'(s_tuser) == dsch_pkg::OP_SUBMIT) && table_full;
        end
        cmp_idx_reg <= scan_idx_reg;
        if (take_cand) begin
            best_idx_reg   <= cmp_idx_reg;
            best_entry_reg <= rd_entry;
            lead_seek_reg  <= cand_dist;
        end
        if (load_out) begin
            m_tuser_reg <= full_reg;
            m_tdata_reg <= dsch_pkg::M_TDATA_W'({
                dsch_pkg::PEND_W'(occ_reg),
                write_total,
                read_total,
                latency_total,
                lead_seek_reg,
                best_entry_reg.tag,
                best_entry_reg.mode,
                best_entry_reg.is_write,
                best_entry_reg.block
            });
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    a_occ_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == dsch_pkg::CNT_W'($countones(slot_valid_reg)))
        else $error("occupancy count disagrees with slot valid bits");

    a_update_has_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dsch_pkg::ST_UPDATE |-> best_found_reg)
        else $error("service step reached without a chosen slot");

    a_pick_released: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dsch_pkg::ST_UPDATE |=> !slot_valid_reg[$past(best_idx_reg)])
        else $error("serviced slot still marked valid");

    a_result_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == dsch_pkg::ST_OUTPUT))
        else $error("result raised outside the output step");
`endif

endmodule

// ===== hdl/dsch_ram.sv =====
module dsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/dsch_seek_unit.sv =====
module dsch_seek_unit (
    input  logic [dsch_pkg::BLOCK_BITS-1:0] head,
    input  dsch_pkg::slot_entry_t           entry,
    input  dsch_pkg::policy_t               policy,
    input  logic                            best_found,
    input  logic [dsch_pkg::BLOCK_BITS-1:0] lead_seek,
    input  logic [dsch_pkg::PRIO_W-1:0]     best_prio,
    output logic [dsch_pkg::BLOCK_BITS-1:0] seek_len,
    output logic                            better
);

    logic [dsch_pkg::BLOCK_BITS-1:0] key_dist;
    logic [dsch_pkg::BLOCK_BITS-1:0] key_best;
    logic [dsch_pkg::PRIO_W-1:0]     key_prio;
    logic [dsch_pkg::PRIO_W-1:0]     key_best_prio;

    always_comb begin
        if (entry.block >= head) begin
            seek_len = entry.block - head;
        end else begin
            seek_len = head - entry.block;
        end
        // FCFS flattens the keys so that only the first valid slot wins
        if (policy == dsch_pkg::POL_SSTF) begin
            key_dist      = seek_len;
            key_best      = lead_seek;
            key_prio      = entry.prio;
            key_best_prio = best_prio;
        end else begin
            key_dist      = '0;
            key_best      = '0;
            key_prio      = '0;
            key_best_prio = '0;
        end
        better = !best_found || (key_dist < key_best)
                 || ((key_dist == key_best) && (key_prio < key_best_prio));
    end

endmodule

// ===== hdl/dsch_stats.sv =====
module dsch_stats (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dsch_pkg::stats_upd_t         upd,
    input  logic [dsch_pkg::DELAY_W-1:0] rot_delay,
    output logic [dsch_pkg::LAT_W-1:0]   latency_total,
    output logic [dsch_pkg::TOT_W-1:0]   read_total,
    output logic [dsch_pkg::TOT_W-1:0]   write_total
);

    logic [dsch_pkg::LAT_W-1:0] lat_reg, lat_next;
    logic [dsch_pkg::TOT_W-1:0] reads_reg, reads_next;
    logic [dsch_pkg::TOT_W-1:0] writes_reg, writes_next;
    logic [dsch_pkg::LAT_W:0]   lat_sum;

    always_comb begin
        lat_sum     = {1'b0, lat_reg} + (dsch_pkg::LAT_W + 1)'(upd.seek)
                      + (dsch_pkg::LAT_W + 1)'(rot_delay);
        lat_next    = lat_reg;
        reads_next  = reads_reg;
        writes_next = writes_reg;
        if (upd.en) begin
            // saturate on carry out of the top bit
            lat_next = lat_sum[dsch_pkg::LAT_W] ? '1 : lat_sum[dsch_pkg::LAT_W-1:0];
            if (upd.is_write) begin
                if (writes_reg != '1) begin
                    writes_next = writes_reg + 1'b1;
                end
            end else begin
                if (reads_reg != '1) begin
                    reads_next = reads_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg    <= '0;
            reads_reg  <= '0;
            writes_reg <= '0;
        end else begin
            lat_reg    <= lat_next;
            reads_reg  <= reads_next;
            writes_reg <= writes_next;
        end
    end

    assign latency_total = lat_reg;
    assign read_total    = reads_reg;
    assign write_total   = writes_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS  = 1150;
    localparam int PHASE_ITEMS   = 144;
    localparam int SETTLE_CYCLES = dsch_pkg::TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_GAP       = 12;
    localparam int REPORT_LIMIT  = 10;

    // request fields as packed into s_tdata, lowest bit last
    typedef struct packed {
        logic                            pad;
        logic [dsch_pkg::LEVEL_W-1:0]    level;
        logic                            owner;
        logic [dsch_pkg::TAG_W-1:0]      tag;
        logic [dsch_pkg::MODE_W-1:0]     mode;
        logic                            wr;
        logic [dsch_pkg::BLOCK_BITS-1:0] block;
    } req_word_t;

    // service result as packed into m_tdata, lowest bit last
    typedef struct packed {
        logic                            pad;
        logic [dsch_pkg::PEND_W-1:0]     pending;
        logic [dsch_pkg::TOT_W-1:0]      writes;
        logic [dsch_pkg::TOT_W-1:0]      reads;
        logic [dsch_pkg::LAT_W-1:0]      latency;
        logic [dsch_pkg::BLOCK_BITS-1:0] seek;
        logic [dsch_pkg::TAG_W-1:0]      tag;
        logic [dsch_pkg::MODE_W-1:0]     mode;
        logic                            wr;
        logic [dsch_pkg::BLOCK_BITS-1:0] block;
    } svc_word_t;

    typedef struct {
        logic      full;
        svc_word_t w;
    } svc_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic                             cfg_index;
    logic [dsch_pkg::DELAY_W-1:0]     cfg_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [dsch_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [dsch_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tuser;

    // scheduler state as the testbench tracks it
    logic                             tbl_valid [dsch_pkg::TABLE_DEPTH];
    dsch_pkg::slot_entry_t            tbl_entry [dsch_pkg::TABLE_DEPTH];
    logic [dsch_pkg::BLOCK_BITS-1:0]  head_pos;
    int                               occupied;
    logic [dsch_pkg::LAT_W-1:0]       lat_sum;
    logic [dsch_pkg::TOT_W-1:0]       n_reads;
    logic [dsch_pkg::TOT_W-1:0]       n_writes;
    dsch_pkg::policy_t                cur_policy;
    logic [dsch_pkg::DELAY_W-1:0]     cur_delay;

    svc_t                   due_services [$];
    int                     mismatch_count;
    int                     cycle_count;
    bit                     src_steady;
    bit                     snk_steady;

    disk_request_scheduler_sstf u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int draw_gap(bit steady);
        return steady ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic logic [dsch_pkg::BLOCK_BITS-1:0] seek_from_head(
        logic [dsch_pkg::BLOCK_BITS-1:0] blk);
        return (blk >= head_pos) ? blk - head_pos : head_pos - blk;
    endfunction

    function automatic int pick_slot();
        int                              best;
        logic [dsch_pkg::BLOCK_BITS-1:0] lead_seek;
        logic [dsch_pkg::BLOCK_BITS-1:0] d;
        logic [dsch_pkg::PRIO_W-1:0]     best_prio;
        best      = -1;
        lead_seek = '0;
        best_prio = '0;
        for (int i = 0; i < dsch_pkg::TABLE_DEPTH; i++) begin
            if (tbl_valid[i]) begin
                if (cur_policy == dsch_pkg::POL_FCFS) return i;
                d = seek_from_head(tbl_entry[i].block);
                // nearest block wins, then the lower level, then the lower slot
                if (best < 0 || d < lead_seek ||
                    (d == lead_seek && tbl_entry[i].prio < best_prio)) begin
                    best      = i;
                    lead_seek = d;
                    best_prio = tbl_entry[i].prio;
                end
            end
        end
        return best;
    endfunction

    function automatic void schedule_request(dsch_pkg::opcode_t op, req_word_t r);
        int                              free_idx;
        int                              pick;
        logic                            full;
        logic [dsch_pkg::BLOCK_BITS-1:0] seek_len;
        logic [dsch_pkg::LAT_W:0]        lat_next;
        svc_t                            e;
        full     = 1'b0;
        free_idx = -1;
        if (op == dsch_pkg::OP_SUBMIT) begin
            for (int i = 0; i < dsch_pkg::TABLE_DEPTH; i++)
                if (!tbl_valid[i] && free_idx < 0) free_idx = i;
            if (free_idx < 0) begin
                full = 1'b1;
            end else begin
                tbl_valid[free_idx]          = 1'b1;
                tbl_entry[free_idx].block    = r.block;
                tbl_entry[free_idx].is_write = r.wr;
                tbl_entry[free_idx].mode     = r.mode;
                tbl_entry[free_idx].tag      = r.tag;
                tbl_entry[free_idx].prio     = r.owner ? dsch_pkg::PRIO_W'(r.level)
                                                       : dsch_pkg::KERNEL_PRIORITY;
                occupied++;
            end
        end
        pick = pick_slot();
        if (pick < 0) return;
        seek_len         = seek_from_head(tbl_entry[pick].block);
        tbl_valid[pick]  = 1'b0;
        if (occupied > 0) occupied--;
        head_pos         = tbl_entry[pick].block;
        lat_next         = {1'b0, lat_sum} + (dsch_pkg::LAT_W + 1)'(seek_len)
                           + (dsch_pkg::LAT_W + 1)'(cur_delay);
        lat_sum          = lat_next[dsch_pkg::LAT_W] ? '1 : lat_next[dsch_pkg::LAT_W-1:0];
        if (tbl_entry[pick].is_write) begin
            if (n_writes != '1) n_writes++;
        end else begin
            if (n_reads != '1) n_reads++;
        end
        e.full      = full;
        e.w.pad     = 1'b0;
        e.w.block   = tbl_entry[pick].block;
        e.w.wr      = tbl_entry[pick].is_write;
        e.w.mode    = tbl_entry[pick].mode;
        e.w.tag     = tbl_entry[pick].tag;
        e.w.seek    = seek_len;
        e.w.latency = lat_sum;
        e.w.reads   = n_reads;
        e.w.writes  = n_writes;
        e.w.pending = dsch_pkg::PEND_W'(occupied);
        due_services.push_back(e);
    endfunction

    function automatic req_word_t make_req(logic [dsch_pkg::BLOCK_BITS-1:0] block, logic wr,
                                           logic [dsch_pkg::MODE_W-1:0] mode,
                                           logic [dsch_pkg::TAG_W-1:0] tag,
                                           logic owner, logic [dsch_pkg::LEVEL_W-1:0] level);
        req_word_t r;
        r.pad   = 1'b0;
        r.level = level;
        r.owner = owner;
        r.tag   = tag;
        r.mode  = mode;
        r.wr    = wr;
        r.block = block;
        return r;
    endfunction

    function automatic req_word_t random_req();
        req_word_t r;
        r     = req_word_t'($urandom);
        r.pad = 1'b0;
        case ($urandom_range(0, 7))
            0: r.block = '0;
            1: r.block = '1;
            2: r.block = head_pos + dsch_pkg::BLOCK_BITS'($urandom_range(0, 3))
                         - dsch_pkg::BLOCK_BITS'(1);
            default: ;
        endcase
        return r;
    endfunction

    // s_tvalid stays high between back-to-back items
    task automatic send_request(dsch_pkg::opcode_t op, req_word_t r);
        int gap;
        gap = draw_gap(src_steady);
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= dsch_pkg::S_TDATA_W'(r);
        do @(posedge aclk); while (!s_tready);
        schedule_request(op, r);
    endtask

    // drop valid and let every outstanding service come back
    task automatic wait_idle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (due_services.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(dsch_pkg::cfg_reg_t idx, logic [dsch_pkg::DELAY_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == dsch_pkg::REG_POLICY) cur_policy = dsch_pkg::policy_t'(value[0]);
        else                             cur_delay  = value;
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_drain();
        send_request(dsch_pkg::OP_DRAIN, make_req('1, 1'b1, '1, '1, 1'b1, '1));
        send_request(dsch_pkg::OP_SUBMIT, make_req(16'h1234, 1'b0, 2'd1, 8'h5a, 1'b1, 3'd2));
        send_request(dsch_pkg::OP_DRAIN, make_req('0, 1'b0, '0, '0, 1'b0, '0));
        wait_idle();
    endtask

    task automatic test_field_extremes();
        send_request(dsch_pkg::OP_SUBMIT, make_req('1, 1'b1, '1, '1, 1'b1, '1));
        send_request(dsch_pkg::OP_SUBMIT, make_req('0, 1'b0, '0, '0, 1'b0, '0));
        send_request(dsch_pkg::OP_SUBMIT, make_req(16'h8000, 1'b1, 2'd2, 8'h80, 1'b0, '1));
        send_request(dsch_pkg::OP_SUBMIT, make_req(16'h7fff, 1'b0, 2'd1, 8'h7f, 1'b1, '0));
        send_request(dsch_pkg::OP_SUBMIT, make_req('1, 1'b0, '0, '1, 1'b1, 3'd4));
        send_request(dsch_pkg::OP_DRAIN, make_req('1, 1'b1, '1, '1, 1'b1, '1));
        wait_idle();
    endtask

    task automatic test_policy_settings();
        write_reg(dsch_pkg::REG_POLICY, dsch_pkg::DELAY_W'(dsch_pkg::POL_SSTF));
        write_reg(dsch_pkg::REG_ROT_DELAY, '0);
        send_request(dsch_pkg::OP_SUBMIT, make_req(16'h0100, 1'b0, 2'd3, 8'h11, 1'b1, 3'd1));
        send_request(dsch_pkg::OP_SUBMIT, make_req(16'h00ff, 1'b1, 2'd0, 8'h22, 1'b0, 3'd0));
        send_request(dsch_pkg::OP_SUBMIT, make_req(16'h0101, 1'b0, 2'd2, 8'h33, 1'b1, 3'd6));
        wait_idle();
        write_reg(dsch_pkg::REG_ROT_DELAY, '1);
        send_request(dsch_pkg::OP_SUBMIT, make_req('0, 1'b1, 2'd1, 8'h44, 1'b1, 3'd3));
        send_request(dsch_pkg::OP_SUBMIT, make_req('1, 1'b0, 2'd2, 8'h55, 1'b0, 3'd5));
        send_request(dsch_pkg::OP_SUBMIT, make_req('0, 1'b1, 2'd3, 8'h66, 1'b1, 3'd7));
        wait_idle();
        write_reg(dsch_pkg::REG_POLICY, dsch_pkg::DELAY_W'(dsch_pkg::POL_FCFS));
    endtask

    // no idling on either side: items arrive while results are still held
    task automatic test_back_to_back();
        src_steady = 1'b1;
        snk_steady = 1'b1;
        for (int i = 0; i < 6; i++)
            send_request(dsch_pkg::OP_SUBMIT, random_req());
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [dsch_pkg::DELAY_W-1:0] delay;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                if (n != 0) wait_idle();
                case (n / PHASE_ITEMS)
                    0:       delay = '1;
                    1:       delay = '0;
                    default: delay = dsch_pkg::DELAY_W'($urandom);
                endcase
                write_reg(dsch_pkg::REG_POLICY, dsch_pkg::DELAY_W'($urandom_range(0, 1)));
                write_reg(dsch_pkg::REG_ROT_DELAY, delay);
                src_steady = ($urandom_range(0, 3) == 0);
                snk_steady = ($urandom_range(0, 3) == 0);
            end
            send_request(($urandom_range(0, 9) < 7) ? dsch_pkg::OP_SUBMIT : dsch_pkg::OP_DRAIN,
                         random_req());
        end
        wait_idle();
    endtask

    // receiver: stall a random number of cycles before each transfer
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = draw_gap(snk_steady);
            if (gap > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        svc_t      e;
        svc_word_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = svc_word_t'(m_tdata);
            if (due_services.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: block %h tag %h", got.block, got.tag);
            end else begin
                e = due_services.pop_front();
                compare_field("full_error",        64'(e.full),      64'(m_tuser));
                compare_field("out_block_number",  64'(e.w.block),   64'(got.block));
                compare_field("out_is_write",      64'(e.w.wr),      64'(got.wr));
                compare_field("out_transfer_mode", 64'(e.w.mode),    64'(got.mode));
                compare_field("out_buffer_tag",    64'(e.w.tag),     64'(got.tag));
                compare_field("seek_distance",     64'(e.w.seek),    64'(got.seek));
                compare_field("latency_total",     64'(e.w.latency), 64'(got.latency));
                compare_field("read_total",        64'(e.w.reads),   64'(got.reads));
                compare_field("write_total",       64'(e.w.writes),  64'(got.writes));
                compare_field("pending_count",     64'(e.w.pending), 64'(got.pending));
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = 1'b0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        src_steady = 1'b0;
        snk_steady = 1'b0;
        mismatch_count = 0;
        for (int i = 0; i < dsch_pkg::TABLE_DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_entry[i] = '0;
        end
        head_pos   = '0;
        occupied   = 0;
        lat_sum    = '0;
        n_reads    = '0;
        n_writes   = '0;
        cur_policy = dsch_pkg::POL_FCFS;
        cur_delay  = dsch_pkg::DELAY_W'(1);
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_empty_drain();
        test_field_extremes();
        test_policy_settings();
        test_back_to_back();
        test_random_traffic();

        mismatch_count += due_services.size();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
